// ----- hdl/tapid_pkg.sv -----
package tapid_pkg;

    localparam int AXES_DEF   = 3;
    localparam int ERR_W_DEF  = 16;
    localparam int NUM_FIELDS = 3;

    // register file
    localparam int APB_AW    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEG    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd4;

    localparam logic [15:0] RST_GAIN_PROP     = 16'd51;
    localparam logic [15:0] RST_GAIN_INTEG    = 16'd0;
    localparam logic [15:0] RST_GAIN_DERIV    = 16'd51;
    localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd13107;
    localparam logic [15:0] RST_SAMPLE_RATE   = 16'd1280;

    // digit-serial multiplier: coefficient operand taken one digit per cycle
    localparam int MUL_DIG  = 4;
    localparam int MUL_OPW  = 17;
    localparam int MUL_NDIG = (MUL_OPW + MUL_DIG - 1) / MUL_DIG;
    localparam int MUL_BW   = MUL_NDIG * MUL_DIG;

endpackage

// ----- hdl/three_axis_pid_top.sv -----
// s_axis_tready is high only in idle: no new item is accepted until the last result
// has been loaded into the output register; each axis is worked out on the one shared
// digit-serial multiplier, one 4-bit coefficient digit per cycle,
// five products per axis
// reset: synchronous active low, registers to their defaults, integrators and previous errors zero
module three_axis_pid_top #(
    parameter int AXES      = tapid_pkg::AXES_DEF,
    parameter int ERR_WIDTH = tapid_pkg::ERR_W_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  s_axis_tvalid,
    output logic                                                  s_axis_tready,
    // err_xy, err_zx, err_yz
    input  logic [((tapid_pkg::NUM_FIELDS*ERR_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                                  m_axis_tvalid,
    input  logic                                                  m_axis_tready,
    // drive_xy, drive_zx, drive_yz
    output logic [((tapid_pkg::NUM_FIELDS*ERR_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input  logic                                                  psel,
    input  logic                                                  penable,
    input  logic                                                  pwrite,
    input  logic [tapid_pkg::APB_AW-1:0]                          paddr,
    input  logic [31:0]                                           pwdata,
    output logic [31:0]                                           prdata,
    output logic                                                  pready
);
    import tapid_pkg::*;

    localparam int W      = ERR_WIDTH;
    localparam int DW     = W + 1;
    localparam int KW_RAW = W + 17;
    localparam int KW     = (KW_RAW > 49) ? 49 : KW_RAW;
    localparam int MW     = (KW > 32) ? KW : 32;
    localparam int PW     = MW + MUL_OPW;
    localparam int IW     = PW - 8;
    localparam int SW     = PW + 2;
    localparam int DG_W   = $clog2(MUL_NDIG + 1);
    localparam int AX_W   = (AXES > 1) ? $clog2(AXES) : 1;

    localparam logic signed [PW-1:0] DLIM  = PW'(64'sh0000_8000_0000_0000);
    localparam logic signed [PW-1:0] NDLIM = -DLIM;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam logic [2:0] OP_SETUP = 3'd0;
    localparam logic [2:0] OP_INT   = 3'd1;
    localparam logic [2:0] OP_PROP  = 3'd2;
    localparam logic [2:0] OP_INTEG = 3'd3;
    localparam logic [2:0] OP_DIFF  = 3'd4;
    localparam logic [2:0] OP_RATE  = 3'd5;

    logic [15:0] r_kp, r_ki, r_kd, r_per, r_rate;

    logic [1:0]             r_state, n_state;
    logic [2:0]             r_op, n_op;
    logic [DG_W-1:0]        r_dig, n_dig;
    logic [AX_W-1:0]        r_axis, n_axis;
    logic signed [PW-1:0]   r_mcand, n_mcand;
    logic [MUL_BW-1:0]      r_mplier, n_mplier;
    logic signed [PW-1:0]   r_acc, n_acc;
    logic signed [SW-1:0]   r_sum, n_sum;
    logic signed [W-1:0]    r_e, n_e;
    logic signed [DW-1:0]   r_d, n_d;
    logic signed [31:0]     r_integ_new, n_integ_new;
    logic                   r_ovalid, n_ovalid;

    logic signed [W-1:0]    r_in    [AXES];
    logic signed [W-1:0]    n_in    [AXES];
    logic signed [W-1:0]    r_drv   [AXES];
    logic signed [W-1:0]    n_drv   [AXES];
    logic signed [W-1:0]    r_out   [AXES];
    logic signed [W-1:0]    n_out   [AXES];
    logic signed [31:0]     r_integ [AXES];
    logic signed [31:0]     n_integ [AXES];
    logic signed [W-1:0]    r_prev  [AXES];
    logic signed [W-1:0]    n_prev  [AXES];

    logic                   w_s_fire, w_m_fire, w_cfg_wr;
    logic [REG_IDX_W-1:0]   w_reg_idx;
    logic signed [W-1:0]    w_cur_e, w_cur_prev;
    logic signed [31:0]     w_cur_integ;
    logic signed [DW-1:0]   w_s, w_dd;
    logic signed [MUL_DIG:0] w_digit;
    logic signed [PW-1:0]   w_pp;
    logic signed [IW-1:0]   w_inc_sum;
    logic signed [31:0]     w_integ_sat;
    logic signed [PW-1:0]   w_kdiff;
    logic signed [SW-1:0]   w_term, w_tot;
    logic signed [SW-9:0]   w_tot_q;
    logic signed [W-1:0]    w_drive;
    logic                   w_mul_step;

    assign w_s_fire  = s_axis_tvalid && s_axis_tready;
    assign w_m_fire  = m_axis_tvalid && m_axis_tready;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[APB_AW-1:2];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign pready        = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= RST_GAIN_PROP;
            r_ki   <= RST_GAIN_INTEG;
            r_kd   <= RST_GAIN_DERIV;
            r_per  <= RST_SAMPLE_PERIOD;
            r_rate <= RST_SAMPLE_RATE;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_GAIN_PROP:     r_kp   <= pwdata[15:0];
                REG_GAIN_INTEG:    r_ki   <= pwdata[15:0];
                REG_GAIN_DERIV:    r_kd   <= pwdata[15:0];
                REG_SAMPLE_PERIOD: r_per  <= pwdata[15:0];
                REG_SAMPLE_RATE:   r_rate <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_GAIN_PROP:     prdata = 32'(r_kp);
            REG_GAIN_INTEG:    prdata = 32'(r_ki);
            REG_GAIN_DERIV:    prdata = 32'(r_kd);
            REG_SAMPLE_PERIOD: prdata = 32'(r_per);
            REG_SAMPLE_RATE:   prdata = 32'(r_rate);
            default:           prdata = '0;
        endcase
    end

    // datapath
    assign w_cur_e     = r_in[r_axis];
    assign w_cur_prev  = r_prev[r_axis];
    assign w_cur_integ = r_integ[r_axis];

    assign w_s  = DW'(w_cur_e) + DW'(w_cur_prev);
    assign w_dd = DW'(w_cur_e) - DW'(w_cur_prev);

    // top digit carries the sign of the coefficient
    assign w_digit = (r_dig == DG_W'(MUL_NDIG - 1)) ?
                     {r_mplier[MUL_DIG-1], r_mplier[MUL_DIG-1:0]} :
                     {1'b0, r_mplier[MUL_DIG-1:0]};
    assign w_pp    = r_mcand * w_digit;

    assign w_inc_sum   = IW'(w_cur_integ) + IW'($signed(r_acc[PW-1:9]));
    assign w_integ_sat = (&w_inc_sum[IW-1:31] || ~|w_inc_sum[IW-1:31]) ? w_inc_sum[31:0] :
                         (w_inc_sum[IW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    assign w_kdiff = (r_acc > DLIM) ? DLIM : ((r_acc < NDLIM) ? NDLIM : r_acc);

    assign w_term  = SW'($signed(r_acc[PW-1:8]));
    assign w_tot   = r_sum + w_term;
    assign w_tot_q = w_tot[SW-1:8];
    assign w_drive = (&w_tot_q[SW-9:W-1] || ~|w_tot_q[SW-9:W-1]) ? w_tot_q[W-1:0] :
                     (w_tot_q[SW-9] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

    assign w_mul_step = (r_op != OP_SETUP) && (r_dig != DG_W'(MUL_NDIG));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_dig       = r_dig;
        n_axis      = r_axis;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_acc       = r_acc;
        n_sum       = r_sum;
        n_e         = r_e;
        n_d         = r_d;
        n_integ_new = r_integ_new;
        n_ovalid    = r_ovalid;
        n_in        = r_in;
        n_drv       = r_drv;
        n_out       = r_out;
        n_integ     = r_integ;
        n_prev      = r_prev;

        if (w_m_fire) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    for (int k = 0; k < AXES; k++) begin
                        n_in[k] = s_axis_tdata[k*W +: W];
                    end
                    n_state = ST_RUN;
                    n_axis  = '0;
                    n_op    = OP_SETUP;
                    n_dig   = '0;
                end
            end
            ST_RUN: begin
                if (w_mul_step) begin
                    n_acc    = r_acc + w_pp;
                    n_mcand  = r_mcand <<< MUL_DIG;
                    n_mplier = r_mplier >> MUL_DIG;
                    n_dig    = r_dig + 1'b1;
                end else begin
                    n_acc = '0;
                    n_dig = '0;
                    case (r_op)
                        OP_SETUP: begin
                            n_e      = w_cur_e;
                            n_d      = w_dd;
                            n_mcand  = PW'(w_s);
                            n_mplier = MUL_BW'(r_per);
                            n_op     = OP_INT;
                        end
                        OP_INT: begin
                            n_integ_new = w_integ_sat;
                            n_mcand     = PW'(r_e);
                            n_mplier    = MUL_BW'($signed(r_kp));
                            n_op        = OP_PROP;
                        end
                        OP_PROP: begin
                            n_sum    = SW'(r_acc);
                            n_mcand  = PW'(r_integ_new);
                            n_mplier = MUL_BW'($signed(r_ki));
                            n_op     = OP_INTEG;
                        end
                        OP_INTEG: begin
                            n_sum    = w_tot;
                            n_mcand  = PW'(r_d);
                            n_mplier = MUL_BW'($signed(r_kd));
                            n_op     = OP_DIFF;
                        end
                        OP_DIFF: begin
                            n_mcand  = w_kdiff;
                            n_mplier = MUL_BW'(r_rate);
                            n_op     = OP_RATE;
                        end
                        OP_RATE: begin
                            n_drv[r_axis]   = w_drive;
                            n_integ[r_axis] = r_integ_new;
                            n_prev[r_axis]  = r_e;
                            n_op            = OP_SETUP;
                            if (r_axis == AX_W'(AXES - 1)) begin
                                n_state = ST_HOLD;
                            end else begin
                                n_axis = r_axis + 1'b1;
                            end
                        end
                        default: begin
                            n_op = OP_SETUP;
                        end
                    endcase
                end
            end
            ST_HOLD: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_out    = r_drv;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_SETUP;
            r_dig    <= '0;
            r_axis   <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_integ[k] <= '0;
                r_prev[k]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_dig    <= n_dig;
            r_axis   <= n_axis;
            r_ovalid <= n_ovalid;
            r_integ  <= n_integ;
            r_prev   <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mcand     <= n_mcand;
        r_mplier    <= n_mplier;
        r_acc       <= n_acc;
        r_sum       <= n_sum;
        r_e         <= n_e;
        r_d         <= n_d;
        r_integ_new <= n_integ_new;
        r_in        <= n_in;
        r_drv       <= n_drv;
        r_out       <= n_out;
    end

    always_comb begin
        m_axis_tdata = '0;
        for (int k = 0; k < AXES; k++) begin
            m_axis_tdata[k*W +: W] = r_out[k];
        end
    end

    // checks
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire |=> (r_state == ST_RUN) && (r_axis == '0) && (r_op == OP_SETUP))
        else $error("run did not start at first axis after input transfer");

    a_dig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dig <= DG_W'(MUL_NDIG))
        else $error("digit counter out of range");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_axis <= AX_W'(AXES - 1)))
        else $error("axis counter out of range");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_HOLD) && (!r_ovalid || m_axis_tready))
            |=> m_axis_tvalid && (r_state == ST_IDLE))
        else $error("finished result not presented");

endmodule
